// ===== src/isle_pkg.sv =====
// Shared types and constants for the indexed sequence list engine.
// Used by isle_ctrl, isle_dpath and indexed_sequence_list_engine; no dependencies.
package isle_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int OP_W         = 4;
   localparam int POS_W        = 5;
   localparam int VAL_W        = 32;
   localparam int CNT_OUT_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 4'd0,
      OP_PREPEND  = 4'd1,
      OP_DEL_HEAD = 4'd2,
      OP_DEL_TAIL = 4'd3,
      OP_READ     = 4'd4,
      OP_WRITE    = 4'd5,
      OP_INSERT   = 4'd6,
      OP_DEL_AT   = 4'd7,
      OP_CLEAR    = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADIDX = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_TAIL = 2'd2
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;     // capture request word
      logic exec;     // apply the list operation
      logic finish;   // build the response word
   } ctrl_cmd_type;

endpackage

// ===== src/isle_ctrl.sv =====
// Sequencer for the list engine: accepts a request word and steps the datapath.
// Depends on isle_pkg.
module isle_ctrl
   import isle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      busy         = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_TAIL;
         end
         S_TAIL: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/isle_dpath.sv =====
// List storage as a row of shifting cells, operation decode and response registers.
// Depends on isle_pkg; stepped by isle_ctrl through ctrl_cmd_type.
module isle_dpath
   import isle_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_cmd_type                cmd,
   input  logic [OP_W-1:0]             req_operation,
   input  logic [POS_W-1:0]            req_position,
   input  logic signed [VAL_W-1:0]     req_item_value,
   output logic [1:0]                  rsp_status,
   output logic signed [VAL_W-1:0]     rsp_read_value,
   output logic [CNT_OUT_W-1:0]        rsp_entry_count,
   output logic signed [VAL_W-1:0]     rsp_head_value,
   output logic signed [VAL_W-1:0]     rsp_tail_value
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int XW    = (CW > POS_W) ? CW : POS_W;

   logic [VAL_W-1:0] entries_ff [CAPACITY];
   logic [VAL_W-1:0] entries_in [CAPACITY];
   logic [VAL_W-1:0] prev_w     [CAPACITY];
   logic [VAL_W-1:0] next_w     [CAPACITY];

   logic [CW-1:0]    count_ff, count_in;
   op_type           op_ff;
   logic [POS_W-1:0] pos_ff;
   logic [VAL_W-1:0] val_ff;
   status_type       status_ff, status_in;
   logic [VAL_W-1:0] rd_ff, rd_in;

   logic [1:0]           rsp_status_ff;
   logic [VAL_W-1:0]     rsp_read_ff, rsp_head_ff, rsp_tail_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;

   logic [XW-1:0]    xpos, xcount, gap;
   logic [CW-1:0]    tail_idx;
   logic [IDX_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_word;
   logic             full, empty, shift_up, shift_dn, wr_en;

   assign xpos     = XW'(pos_ff);
   assign xcount   = XW'(count_ff);
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign tail_idx = CW'(count_ff - 1'b1);

   // single read port: position during execute, tail while building the response
   assign rd_addr = cmd.exec ? xpos[IDX_W-1:0] : tail_idx[IDX_W-1:0];
   assign rd_word = entries_ff[rd_addr];

   // neighbor taps of each cell; end cells feed themselves or the new word
   for (genvar i = 0; i < CAPACITY; i++) begin : g_tap
      if (i == 0) begin : g_first
         assign prev_w[i] = val_ff;
      end else begin : g_mid
         assign prev_w[i] = entries_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w[i] = entries_ff[i];
      end else begin : g_body
         assign next_w[i] = entries_ff[i+1];
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      shift_up  = 1'b0;
      shift_dn  = 1'b0;
      wr_en     = 1'b0;
      gap       = '0;
      if (cmd.exec) begin
         status_in = ST_OK;
         rd_in     = '0;
         unique case (op_ff)
            OP_APPEND, OP_PREPEND: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  shift_up = 1'b1;
                  gap      = (op_ff == OP_APPEND) ? xcount : '0;
                  count_in = CW'(count_ff + 1'b1);
               end
            end
            OP_DEL_HEAD: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  shift_dn = 1'b1;
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            OP_DEL_TAIL: begin
               if (empty) status_in = ST_EMPTY;
               else count_in = CW'(count_ff - 1'b1);
            end
            OP_READ: begin
               if (xpos >= xcount) status_in = ST_BADIDX;
               else rd_in = rd_word;
            end
            OP_WRITE: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else if (xpos >= xcount) begin
                  status_in = ST_BADIDX;
               end else begin
                  wr_en = 1'b1;
                  gap   = xpos;
               end
            end
            OP_INSERT: begin
               if (xpos > xcount) begin
                  status_in = ST_BADIDX;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  shift_up = 1'b1;
                  gap      = xpos;
                  count_in = CW'(count_ff + 1'b1);
               end
            end
            OP_DEL_AT: begin
               if (xpos >= xcount) begin
                  status_in = ST_BADIDX;
               end else begin
                  shift_dn = 1'b1;
                  gap      = xpos;
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // every cell decides its own next value from its neighbors
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if ((wr_en || shift_up) && XW'(i) == gap) entries_in[i] = val_ff;
         else if (shift_up && XW'(i) > gap) entries_in[i] = prev_w[i];
         else if (shift_dn && XW'(i) >= gap) entries_in[i] = next_w[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      status_ff  <= status_in;
      rd_ff      <= rd_in;
      if (cmd.load) begin
         op_ff  <= op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_read_ff   <= rd_ff;
         rsp_count_ff  <= CNT_OUT_W'(count_ff);
         rsp_head_ff   <= empty ? '0 : entries_ff[0];
         rsp_tail_ff   <= empty ? '0 : rd_word;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_head_value  = rsp_head_ff;
   assign rsp_tail_value  = rsp_tail_ff;

endmodule

// ===== src/indexed_sequence_list_engine.sv =====
// Top level of the indexed sequence list engine: controller plus datapath.
// Depends on isle_pkg, isle_ctrl and isle_dpath.
//
// Bounded ordered list of signed 32-bit words, up to CAPACITY entries.
// Request channel: drive req_operation, req_position and req_item_value with
// start high; the word is taken at a rising edge where start is high and busy
// is low. busy stays high while the command is at work, in the execute and tail states.
// Response channel: rsp_valid is high for exactly one cycle with status, the
// read word, the entry count and the head and tail words as they stand after
// the command. There is no back-pressure; the receiver must take each word
// in that cycle.
// Sequence: the accepting edge moves the controller to the execute state,
// which shifts the cell row; the tail state then reads the tail word through
// the shared read port into the output registers as rsp_valid rises.
// A new request can be taken in the cycle the response is out, not while the
// previous command is still in the execute or tail state.
// Reset (synchronous, active high) empties the list and drops any pending
// response; the stored words themselves are not cleared.
module indexed_sequence_list_engine
   import isle_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [CNT_OUT_W-1:0]    rsp_entry_count,
   output logic signed [VAL_W-1:0] rsp_head_value,
   output logic signed [VAL_W-1:0] rsp_tail_value
);

   ctrl_cmd_type cmd;

   isle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   isle_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_head_value  (rsp_head_value),
      .rsp_tail_value  (rsp_tail_value)
   );

   // accepted word always yields its response after the execute and tail states
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing after accepted request");

   // a response never overlaps work in progress
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // an accepted word locks out the request port
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy)
      else $error("busy not held while command executes");

endmodule
